FILE: sv/vlia_pkg.sv
// ----------------------------------------------------------------------------
// vlia_pkg: shared types and constants of the vector lane integer ALU
// Opcode names, input/output transaction structs and the front/back record.
// ----------------------------------------------------------------------------
package vlia_pkg;

  localparam int unsigned WaveLanes = 64;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QIdxW     = 1;

  typedef enum logic [5:0] {
    OP_ADD_I16 = 6'd0, OP_ADD_I32 = 6'd1, OP_ADD3_U32 = 6'd2, OP_ADD_LSHL = 6'd3,
    OP_ALIGNBIT = 6'd4, OP_ALIGNBYTE = 6'd5, OP_AND_OR = 6'd6, OP_ASHR_I64 = 6'd7,
    OP_ASHRREV_I64 = 6'd8, OP_BCNT = 6'd9, OP_BFE_I32 = 6'd10, OP_BFE_U32 = 6'd11,
    OP_BFI = 6'd12, OP_BFM = 6'd13, OP_CVT_PK_I16 = 6'd14, OP_CVT_PK_U16 = 6'd15,
    OP_LERP_U8 = 6'd16, OP_LSHL_ADD = 6'd17, OP_LSHL_B64 = 6'd18, OP_LSHL_OR = 6'd19,
    OP_LSHLREV_B64 = 6'd20, OP_LSHR_B64 = 6'd21, OP_LSHRREV_B64 = 6'd22,
    OP_MAD_I16 = 6'd23, OP_MAD_I32_I16 = 6'd24, OP_MAD_I32_I24 = 6'd25,
    OP_MAD_LEG_I16 = 6'd26, OP_MAD_LEG_U16 = 6'd27, OP_MAD_U16 = 6'd28,
    OP_MAD_U32_U16 = 6'd29, OP_MAD_U32_U24 = 6'd30,
    OP_MAX3_I16 = 6'd31, OP_MAX3_I32 = 6'd32, OP_MAX3_U16 = 6'd33, OP_MAX3_U32 = 6'd34,
    OP_MBCNT_HI = 6'd35, OP_MBCNT_LO = 6'd36,
    OP_MED3_I16 = 6'd37, OP_MED3_I32 = 6'd38, OP_MED3_U16 = 6'd39, OP_MED3_U32 = 6'd40,
    OP_MIN3_I16 = 6'd41, OP_MIN3_I32 = 6'd42, OP_MIN3_U16 = 6'd43, OP_MIN3_U32 = 6'd44,
    OP_MSAD_U8 = 6'd45, OP_MUL_HI_I32 = 6'd46, OP_MUL_HI_U32 = 6'd47,
    OP_MUL_LO_I32 = 6'd48, OP_OR3 = 6'd49, OP_PACK_B32 = 6'd50, OP_PERM = 6'd51,
    OP_SAD_HI_U8 = 6'd52, OP_SAD_U16 = 6'd53, OP_SAD_U32 = 6'd54, OP_SAD_U8 = 6'd55,
    OP_SUB_I16 = 6'd56, OP_SUB_I32 = 6'd57, OP_XAD_U32 = 6'd58, OP_MUL_LO_U32 = 6'd59,
    OP_ADDC_CO = 6'd60, OP_RSV61 = 6'd61, OP_RSV62 = 6'd62, OP_RSV63 = 6'd63
  } opcode_e;

  localparam logic [5:0] OpLastValid = 6'd60;

  typedef struct packed {
    logic [5:0]  cmd;
    logic [63:0] src_a;
    logic [63:0] src_b;
    logic [63:0] src_c;
    logic [5:0]  lane_number;
    logic        lane_active;
  } in_item_t;

  typedef struct packed {
    logic [63:0] dest_value;
    logic        carry_out;
    logic        carry_valid;
    logic        write_enable;
    logic        unsupported;
  } out_item_t;

  // Decoded instruction handed from front to back
  typedef struct packed {
    opcode_e     op;
    logic [63:0] src_a;
    logic [63:0] src_b;
    logic [63:0] src_c;
    logic [63:0] below;
    logic        wr_en;
    logic        unsup;
  } dec_item_t;

endpackage

FILE: sv/vlia_front.sv
// ----------------------------------------------------------------------------
// vlia_front: instruction intake and decode
// Classifies the opcode, computes the lane mask and registers the decoded op.
// ----------------------------------------------------------------------------
module vlia_front import vlia_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      dec_valid_o,
  input  logic      dec_stall_i,
  output dec_item_t dec_data_o
);

  logic      valid_q;
  dec_item_t data_q, data_d;
  logic [6:0] lane_n;

  assign in_stall = valid_q && dec_stall_i;

  // Classify the incoming transaction
  always_comb begin
    lane_n = (7'(in_data.lane_number) < 7'(WaveLanes)) ? 7'(in_data.lane_number)
                                                        : 7'(WaveLanes);
    data_d.op    = opcode_e'(in_data.cmd);
    data_d.src_a = in_data.src_a;
    data_d.src_b = in_data.src_b;
    data_d.src_c = in_data.src_c;
    data_d.below = lane_n[6] ? '1 : ((64'd1 << lane_n[5:0]) - 64'd1);
    data_d.unsup = in_data.cmd > OpLastValid;
    data_d.wr_en = in_data.lane_active && !data_d.unsup;
  end

  // Advance the decode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall && in_valid) begin
      data_q <= data_d;
    end
  end

  assign dec_valid_o = valid_q;
  assign dec_data_o  = data_q;

endmodule

FILE: sv/vlia_queue.sv
// ----------------------------------------------------------------------------
// vlia_queue: decoupling queue between decode and execute
// Small FIFO of decoded transactions; stall is driven by fullness only.
// ----------------------------------------------------------------------------
module vlia_queue import vlia_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  output logic      wr_stall_o,
  input  dec_item_t wr_data_i,
  output logic      rd_valid_o,
  input  logic      rd_stall_i,
  output dec_item_t rd_data_o
);

  dec_item_t        mem_q [QDepth];
  logic [QIdxW-1:0] wp_q, rp_q;
  logic [QIdxW:0]   cnt_q;
  logic             push, pop;

  assign wr_stall_o = cnt_q == (QIdxW+1)'(QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign push       = wr_valid_i && !wr_stall_o;
  assign pop        = rd_valid_o && !rd_stall_i;
  assign rd_data_o  = mem_q[rp_q];

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QIdxW+1)'(push) - (QIdxW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

endmodule

FILE: sv/vlia_back.sv
// ----------------------------------------------------------------------------
// vlia_back: two-stage execute pipeline
// Stage one forms operands and products, stage two adds, selects and masks.
// ----------------------------------------------------------------------------
module vlia_back import vlia_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      dec_valid_i,
  output logic      dec_stall_o,
  input  dec_item_t dec_data_i,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Stage one record
  typedef struct packed {
    opcode_e     op;
    logic [63:0] res;
    logic [63:0] prod;
    logic [31:0] addend;
    logic        wr_en;
    logic        unsup;
  } ex1_t;

  logic      v1_q, v2_q, adv1, adv2;
  ex1_t      s1_q, s1_d;
  out_item_t s2_q, s2_d;

  assign adv2        = !v2_q || !out_stall;
  assign adv1        = !v1_q || adv2;
  assign dec_stall_o = !adv1;

  function automatic logic [15:0] clamp16(input logic [31:0] v);
    logic signed [31:0] s;
    s = signed'(v);
    if (s > 32'sh7fff)       clamp16 = 16'h7fff;
    else if (s < -32'sh8000) clamp16 = 16'h8000;
    else                     clamp16 = v[15:0];
  endfunction

  function automatic logic [31:0] sel3(input logic [1:0] kind, input logic [31:0] a,
                                       input logic [31:0] b, input logic [31:0] c,
                                       input logic [31:0] bias);
    logic [31:0] x, y, z, mn, mx, r;
    x = a ^ bias; y = b ^ bias; z = c ^ bias;
    mn = (x < y) ? x : y;
    mx = (x > y) ? x : y;
    case (kind)
      2'd0:    r = (mx > z) ? mx : z;
      2'd1:    r = (mn < z) ? mn : z;
      default: begin
        r = (mx < z) ? mx : z;
        r = (mn > r) ? mn : r;
      end
    endcase
    sel3 = r ^ bias;
  endfunction

  function automatic logic [7:0] ad8(input logic [7:0] x, input logic [7:0] y);
    ad8 = (x > y) ? x - y : y - x;
  endfunction

  function automatic logic [6:0] pop64(input logic [63:0] x);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) n = n + 7'(x[i]);
    pop64 = n;
  endfunction

  // Stage one: shifts, logic, selections and the multiply
  always_comb begin
    logic [31:0] a, b, c, t, bias;
    logic [63:0] pair, sh;
    logic [4:0]  off, wid;
    logic [9:0]  sum;
    logic [7:0]  byt, sl;
    logic [1:0]  kind;
    logic signed [63:0] sp;
    a = dec_data_i.src_a[31:0];
    b = dec_data_i.src_b[31:0];
    c = dec_data_i.src_c[31:0];
    pair = {a, b};
    off = b[4:0];
    wid = c[4:0];
    t = '0; sh = '0; sum = '0; byt = '0; sl = '0; sp = '0;
    kind = 2'd0; bias = '0;
    s1_d.op     = dec_data_i.op;
    s1_d.wr_en  = dec_data_i.wr_en;
    s1_d.unsup  = dec_data_i.unsup;
    s1_d.res    = '0;
    s1_d.prod   = '0;
    s1_d.addend = '0;
    unique case (dec_data_i.op)
      OP_ADD_I16, OP_ADD_I32, OP_ADDC_CO: begin
        s1_d.prod = {32'd0, a}; s1_d.addend = b;
      end
      OP_ADD3_U32: s1_d.res = {32'd0, a + b + c};
      OP_ADD_LSHL: s1_d.res = {32'd0, (a + b) << c[4:0]};
      OP_ALIGNBIT: begin sh = pair >> c[4:0]; s1_d.res = {32'd0, sh[31:0]}; end
      OP_ALIGNBYTE: begin
        sh = pair >> {c[1:0], 3'b000}; s1_d.res = {32'd0, sh[31:0]};
      end
      OP_AND_OR: s1_d.res = 64'((a & b) | c);
      OP_ASHR_I64:
        s1_d.res = 64'($signed(dec_data_i.src_a) >>> dec_data_i.src_b[5:0]);
      OP_ASHRREV_I64:
        s1_d.res = 64'($signed(dec_data_i.src_b) >>> dec_data_i.src_a[5:0]);
      OP_BCNT: s1_d.res = {32'd0, b + 32'(pop64({32'd0, a}))};
      OP_BFE_I32: begin
        t = 32'($signed(a) >>> off);
        t = t & ((32'd1 << wid) - 32'd1);
        if (t[wid - 5'd1]) t = t | ~((32'd1 << wid) - 32'd1);
        s1_d.res = (wid == 5'd0) ? '0 : {32'd0, t};
      end
      OP_BFE_U32: begin
        t = (a >> off) & ((32'd1 << wid) - 32'd1);
        s1_d.res = {32'd0, t};
      end
      OP_BFI: s1_d.res = 64'((a & b) | (~a & c));
      OP_BFM: s1_d.res = {32'd0, ((32'd1 << a[4:0]) - 32'd1) << b[4:0]};
      OP_CVT_PK_I16: s1_d.res = {32'd0, clamp16(b), clamp16(a)};
      OP_CVT_PK_U16: s1_d.res = {32'd0, (b > 32'hffff) ? 16'hffff : b[15:0],
                                 (a > 32'hffff) ? 16'hffff : a[15:0]};
      OP_LERP_U8: begin
        for (int j = 0; j < 4; j++) begin
          sum = 10'(a[8*j +: 8]) + 10'(b[8*j +: 8]) + 10'(c[8*j]);
          t[8*j +: 8] = sum[8:1];
        end
        s1_d.res = {32'd0, t};
      end
      OP_LSHL_ADD: begin s1_d.prod = {32'd0, a << off}; s1_d.addend = c; end
      OP_LSHL_OR:  s1_d.res = {32'd0, (a << off) | c};
      OP_LSHL_B64: s1_d.res = dec_data_i.src_a << dec_data_i.src_b[5:0];
      OP_LSHLREV_B64: s1_d.res = dec_data_i.src_b << dec_data_i.src_a[5:0];
      OP_LSHR_B64: s1_d.res = dec_data_i.src_a >> dec_data_i.src_b[5:0];
      OP_LSHRREV_B64: s1_d.res = dec_data_i.src_b >> dec_data_i.src_a[5:0];
      OP_MAD_I16, OP_MAD_LEG_I16, OP_MAD_I32_I16: begin
        sp = 64'(signed'(a[15:0])) * 64'(signed'(b[15:0]));
        s1_d.prod = sp;
        s1_d.addend = (dec_data_i.op == OP_MAD_I32_I16) ? c : {16'd0, c[15:0]};
      end
      OP_MAD_I32_I24: begin
        sp = 64'(signed'(a[23:0])) * 64'(signed'(b[23:0]));
        s1_d.prod = sp; s1_d.addend = c;
      end
      OP_MAD_LEG_U16, OP_MAD_U16, OP_MAD_U32_U16: begin
        s1_d.prod = 64'(a[15:0]) * 64'(b[15:0]); s1_d.addend = c;
      end
      OP_MAD_U32_U24: begin s1_d.prod = 64'(a[23:0]) * 64'(b[23:0]); s1_d.addend = c; end
      OP_MAX3_I16, OP_MAX3_U16, OP_MED3_I16, OP_MED3_U16, OP_MIN3_I16,
      OP_MIN3_U16, OP_MAX3_I32, OP_MAX3_U32, OP_MED3_I32, OP_MED3_U32,
      OP_MIN3_I32, OP_MIN3_U32: begin
        kind = (dec_data_i.op <= OP_MAX3_U32) ? 2'd0 :
               (dec_data_i.op <= OP_MED3_U32) ? 2'd2 : 2'd1;
        if (dec_data_i.op inside {OP_MAX3_I16, OP_MED3_I16, OP_MIN3_I16}) bias = 32'h8000;
        if (dec_data_i.op inside {OP_MAX3_I32, OP_MED3_I32, OP_MIN3_I32})
          bias = 32'h8000_0000;
        if (dec_data_i.op inside {OP_MAX3_I16, OP_MAX3_U16, OP_MED3_I16, OP_MED3_U16,
                                  OP_MIN3_I16, OP_MIN3_U16})
          s1_d.res = {32'd0, sel3(kind, {16'd0, a[15:0]}, {16'd0, b[15:0]},
                                  {16'd0, c[15:0]}, bias)};
        else
          s1_d.res = {32'd0, sel3(kind, a, b, c, bias)};
      end
      OP_MBCNT_HI: s1_d.res = {32'd0, b + 32'(pop64({32'd0, a & dec_data_i.below[63:32]}))};
      OP_MBCNT_LO: s1_d.res = {32'd0, b + 32'(pop64({32'd0, a & dec_data_i.below[31:0]}))};
      OP_MSAD_U8, OP_SAD_U8, OP_SAD_HI_U8: begin
        for (int j = 0; j < 4; j++)
          if (dec_data_i.op != OP_MSAD_U8 || b[8*j +: 8] != 8'd0)
            sum = sum + 10'(ad8(a[8*j +: 8], b[8*j +: 8]));
        t = (dec_data_i.op == OP_SAD_HI_U8) ? {6'd0, sum, 16'd0} : {22'd0, sum};
        s1_d.res = {32'd0, c + t};
      end
      OP_MUL_HI_I32, OP_MUL_LO_I32, OP_MUL_LO_U32: begin
        sp = 64'(signed'(a)) * 64'(signed'(b)); s1_d.prod = sp;
      end
      OP_MUL_HI_U32: s1_d.prod = 64'(a) * 64'(b);
      OP_OR3: s1_d.res = 64'(a | b | c);
      OP_PACK_B32: s1_d.res = {32'd0, b[15:0], a[15:0]};
      OP_PERM: begin
        for (int j = 0; j < 4; j++) begin
          sl = c[8*j +: 8];
          if (sl >= 8'd13)      byt = 8'hff;
          else if (sl == 8'd12) byt = 8'h00;
          else if (sl >= 8'd8)  byt = {8{pair[{sl[1:0], 4'hf}]}};
          else                  byt = pair[{sl[2:0], 3'b000} +: 8];
          t[8*j +: 8] = byt;
        end
        s1_d.res = {32'd0, t};
      end
      OP_SAD_U16: s1_d.res = {32'd0, c + ((a[15:0] > b[15:0]) ? a[15:0] - b[15:0]
                                                              : b[15:0] - a[15:0])
                                       + ((a[31:16] > b[31:16]) ? a[31:16] - b[31:16]
                                                                : b[31:16] - a[31:16])};
      OP_SAD_U32: s1_d.res = {32'd0, c + ((a > b) ? a - b : b - a)};
      OP_SUB_I16, OP_SUB_I32: begin s1_d.prod = {32'd0, a}; s1_d.addend = -b; end
      OP_XAD_U32: begin s1_d.prod = {32'd0, a ^ b}; s1_d.addend = c; end
      default: ;
    endcase
  end

  // Stage two: final add, width trim and lane masking
  always_comb begin
    logic [32:0] s;
    logic [31:0] r;
    s = 33'(s1_q.prod[31:0]) + 33'(s1_q.addend);
    r = s[31:0];
    s2_d.dest_value = s1_q.res;
    s2_d.carry_out  = 1'b0;
    case (s1_q.op)
      OP_ADD_I16, OP_SUB_I16, OP_MAD_I16, OP_MAD_LEG_I16, OP_MAD_LEG_U16, OP_MAD_U16:
        s2_d.dest_value = {48'd0, r[15:0]};
      OP_ADD_I32, OP_SUB_I32, OP_LSHL_ADD, OP_XAD_U32, OP_MAD_I32_I16,
      OP_MAD_I32_I24, OP_MAD_U32_U16, OP_MAD_U32_U24, OP_MUL_LO_I32, OP_MUL_LO_U32:
        s2_d.dest_value = {32'd0, r};
      OP_ADDC_CO: begin s2_d.dest_value = {32'd0, r}; s2_d.carry_out = s[32]; end
      OP_MUL_HI_I32, OP_MUL_HI_U32: s2_d.dest_value = {32'd0, s1_q.prod[63:32]};
      default: ;
    endcase
    if (!s1_q.wr_en) begin
      s2_d.dest_value = '0;
      s2_d.carry_out  = 1'b0;
    end
    s2_d.carry_valid  = s1_q.wr_en && s1_q.op == OP_ADDC_CO;
    s2_d.write_enable = s1_q.wr_en;
    s2_d.unsupported  = s1_q.unsup;
  end

  // Advance the execute stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= dec_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && dec_valid_i) s1_q <= s1_d;
    if (adv2 && v1_q)        s2_q <= s2_d;
  end

  assign out_valid = v2_q;
  assign out_data  = s2_q;

endmodule

FILE: sv/vector_lane_integer_alu_unit.sv
// Path from input acceptance to result: decode register, queue, two execute stages.
// Throughput: one transaction per cycle while out_stall is low; the execute multiplier is fully pipelined.
// Reset: asynchronous active-low rst_ni clears all valid flags and queue pointers.
// Payload registers are not reset.
// ----------------------------------------------------------------------------
// vector_lane_integer_alu_unit: one lane of a vector integer ALU
// Front decode, decoupling queue and two-stage execute back end.
// ----------------------------------------------------------------------------
module vector_lane_integer_alu_unit import vlia_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      f_valid, f_stall, q_valid, q_stall;
  dec_item_t f_data, q_data;

  vlia_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data,
    .dec_valid_o(f_valid), .dec_stall_i(f_stall), .dec_data_o(f_data)
  );

  vlia_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i(f_data),
    .rd_valid_o(q_valid), .rd_stall_i(q_stall), .rd_data_o(q_data)
  );

  vlia_back u_back (
    .clk_i, .rst_ni,
    .dec_valid_i(q_valid), .dec_stall_o(q_stall), .dec_data_i(q_data),
    .out_valid, .out_stall, .out_data
  );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the vector lane integer ALU
// Drives instructions through the valid/stall input channel, predicts each
// lane result in a behavioral model and compares it with the output channel.
// ----------------------------------------------------------------------------
module testbench;
  import vlia_pkg::*;

  localparam longint unsigned M16 = 64'hffff;
  localparam longint unsigned M32 = 64'hffff_ffff;
  localparam int unsigned CycleLimit = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  out_item_t   expected_q[$];
  int unsigned err_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;

  vector_lane_integer_alu_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk_i = ~clk_i;

  // ---------------- lane result predictor ----------------
  function automatic longint unsigned sx(longint unsigned x, int bits);
    longint unsigned m, s;
    m = (64'd1 << bits) - 1;
    s = 64'd1 << (bits - 1);
    return ((x & m) ^ s) - s;
  endfunction

  function automatic longint unsigned sar(longint unsigned x, int s);
    return longint'($signed(x) >>> (s & 63));
  endfunction

  function automatic longint unsigned adiff(longint unsigned x, longint unsigned y);
    return (x > y) ? x - y : y - x;
  endfunction

  function automatic int unsigned ones(longint unsigned x);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 64; i++) n += 32'(x[i]);
    return n;
  endfunction

  // kind 0 max, 1 min, 2 median; bias flips the sign for signed order
  function automatic longint unsigned pick3(int kind, longint unsigned a, longint unsigned b,
                                            longint unsigned c, longint unsigned bias);
    longint unsigned r, lo, hi;
    a ^= bias; b ^= bias; c ^= bias;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (kind == 0) r = (hi > c) ? hi : c;
    else if (kind == 1) r = (lo < c) ? lo : c;
    else begin
      r = (hi < c) ? hi : c;
      r = (lo > r) ? lo : r;
    end
    return r ^ bias;
  endfunction

  function automatic longint unsigned byte_perm(longint unsigned a, longint unsigned b,
                                                longint unsigned c);
    longint unsigned pr, r;
    int unsigned s;
    logic [7:0] bt;
    pr = (a << 32) | b;
    r = 0;
    for (int j = 0; j < 4; j++) begin
      s = 32'((c >> (8 * j)) & 64'hff);
      if (s >= 13) bt = 8'hff;
      else if (s == 12) bt = 8'h00;
      else if (s >= 8) bt = pr[(s - 8) * 16 + 15] ? 8'hff : 8'h00;
      else bt = 8'(pr >> (s * 8));
      r |= longint'(bt) << (8 * j);
    end
    return r;
  endfunction

  // kind 0 sad_u8, 1 sad_hi_u8, 2 msad_u8, 3 lerp_u8
  function automatic longint unsigned byte_sum(int kind, longint unsigned a,
                                               longint unsigned b, longint unsigned c);
    longint unsigned sum, r, x, y;
    sum = 0; r = 0;
    for (int j = 0; j < 4; j++) begin
      x = (a >> (8 * j)) & 8'hff;
      y = (b >> (8 * j)) & 8'hff;
      if (kind == 3) r |= ((x + y + ((c >> (8 * j)) & 1)) >> 1) << (8 * j);
      else if (kind != 2 || y != 0) sum += adiff(x, y);
    end
    if (kind == 3) return r;
    if (kind == 1) sum <<= 16;
    return (c + sum) & M32;
  endfunction

  function automatic longint unsigned sat16(longint unsigned v);
    longint signed s;
    s = longint'(sx(v, 32));
    if (s < -32768) s = -32768;
    if (s > 32767) s = 32767;
    return longint'(s) & M16;
  endfunction

  function automatic out_item_t predict_lane(in_item_t t);
    out_item_t r;
    longint unsigned wa, wb, wc, a, b, c, d, below, bias;
    logic carry, ok;
    int unsigned off, wid, kind;
    opcode_e op;
    wa = t.src_a; wb = t.src_b; wc = t.src_c;
    a = wa & M32; b = wb & M32; c = wc & M32;
    off = 32'(b & 31); wid = 32'(c & 31);
    op = opcode_e'(t.cmd);
    ok = (t.cmd <= OpLastValid);
    below = (t.lane_number >= WaveLanes) ? '1 : ((64'd1 << t.lane_number) - 1);
    d = 0; carry = 1'b0; kind = 0; bias = 0;
    case (op)
      OP_ADD_I16:     d = (a + b) & M16;
      OP_ADD_I32:     d = (a + b) & M32;
      OP_ADD3_U32:    d = (a + b + c) & M32;
      OP_ADD_LSHL:    d = ((a + b) << (c & 31)) & M32;
      OP_ALIGNBIT:    d = (((a << 32) | b) >> (c & 31)) & M32;
      OP_ALIGNBYTE:   d = (((a << 32) | b) >> ((c & 3) * 8)) & M32;
      OP_AND_OR:      d = (a & b) | c;
      OP_ASHR_I64:    d = sar(wa, 32'(wb & 63));
      OP_ASHRREV_I64: d = sar(wb, 32'(wa & 63));
      OP_BCNT:        d = (b + ones(a)) & M32;
      OP_BFE_I32:     d = (wid == 0) ? 0 : sx(sar(sx(a, 32), off), wid) & M32;
      OP_BFE_U32:     d = (wid == 0) ? 0 : (a >> off) & ((64'd1 << wid) - 1);
      OP_BFI:         d = (a & b) | (~a & c & M32);
      OP_BFM:         d = (((64'd1 << (a & 31)) - 1) << (b & 31)) & M32;
      OP_CVT_PK_I16:  d = sat16(a) | (sat16(b) << 16);
      OP_CVT_PK_U16:  d = ((a < M16) ? a : M16) | (((b < M16) ? b : M16) << 16);
      OP_LERP_U8:     d = byte_sum(3, a, b, c);
      OP_LSHL_ADD:    d = ((a << (b & 31)) + c) & M32;
      OP_LSHL_B64:    d = wa << (wb & 63);
      OP_LSHL_OR:     d = ((a << (b & 31)) | c) & M32;
      OP_LSHLREV_B64: d = wb << (wa & 63);
      OP_LSHR_B64:    d = wa >> (wb & 63);
      OP_LSHRREV_B64: d = wb >> (wa & 63);
      OP_MAD_I16, OP_MAD_LEG_I16:
        d = (sx(a, 16) * sx(b, 16) + sx(c, 16)) & M16;
      OP_MAD_I32_I16: d = (sx(a, 16) * sx(b, 16) + c) & M32;
      OP_MAD_I32_I24: d = (sx(a, 24) * sx(b, 24) + c) & M32;
      OP_MAD_LEG_U16, OP_MAD_U16: d = ((a & M16) * (b & M16) + (c & M16)) & M16;
      OP_MAD_U32_U16: d = ((a & M16) * (b & M16) + c) & M32;
      OP_MAD_U32_U24: d = ((a & 64'hffffff) * (b & 64'hffffff) + c) & M32;
      OP_MAX3_I16, OP_MAX3_U16, OP_MED3_I16, OP_MED3_U16, OP_MIN3_I16, OP_MIN3_U16: begin
        kind = (op <= OP_MAX3_U16) ? 0 : ((op <= OP_MED3_U16) ? 2 : 1);
        bias = (op == OP_MAX3_I16 || op == OP_MED3_I16 || op == OP_MIN3_I16) ? 64'h8000 : 0;
        d = pick3(kind, a & M16, b & M16, c & M16, bias);
      end
      OP_MAX3_I32, OP_MAX3_U32, OP_MED3_I32, OP_MED3_U32, OP_MIN3_I32, OP_MIN3_U32: begin
        kind = (op <= OP_MAX3_U32) ? 0 : ((op <= OP_MED3_U32) ? 2 : 1);
        bias = (op == OP_MAX3_I32 || op == OP_MED3_I32 || op == OP_MIN3_I32)
               ? 64'h8000_0000 : 0;
        d = pick3(kind, a, b, c, bias);
      end
      OP_MBCNT_HI:    d = (b + ones(a & (below >> 32))) & M32;
      OP_MBCNT_LO:    d = (b + ones(a & below & M32)) & M32;
      OP_MSAD_U8:     d = byte_sum(2, a, b, c);
      OP_MUL_HI_I32:  d = ((sx(a, 32) * sx(b, 32)) >> 32) & M32;
      OP_MUL_HI_U32:  d = (a * b) >> 32;
      OP_MUL_LO_I32, OP_MUL_LO_U32: d = (a * b) & M32;
      OP_OR3:         d = a | b | c;
      OP_PACK_B32:    d = (a & M16) | ((b & M16) << 16);
      OP_PERM:        d = byte_perm(a, b, c);
      OP_SAD_HI_U8:   d = byte_sum(1, a, b, c);
      OP_SAD_U16:     d = (c + adiff(a & M16, b & M16) + adiff(a >> 16, b >> 16)) & M32;
      OP_SAD_U32:     d = (c + adiff(a, b)) & M32;
      OP_SAD_U8:      d = byte_sum(0, a, b, c);
      OP_SUB_I16:     d = (a - b) & M16;
      OP_SUB_I32:     d = (a - b) & M32;
      OP_XAD_U32:     d = ((a ^ b) + c) & M32;
      OP_ADDC_CO: begin
        d = (a + b) & M32;
        carry = ((a + b) >> 32) != 0;
      end
      default: d = 0;
    endcase
    if (!ok || !t.lane_active) begin
      d = 0;
      carry = 1'b0;
    end
    r.dest_value   = d;
    r.carry_out    = carry;
    r.carry_valid  = ok && t.lane_active && (op == OP_ADDC_CO);
    r.write_enable = ok && t.lane_active;
    r.unsupported  = !ok;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic longint unsigned rand64();
    longint unsigned v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = '1;
      2: v = v & M32;
      3: v = v & M16;
      4: v = 64'h8000_0000 + $urandom_range(0, 3) - 2;
      5: v = $urandom_range(0, 40);
      default: ;
    endcase
    return v;
  endfunction

  // Send one transaction, honoring the current burst/gap pattern
  task automatic send_instr(input logic [5:0] cmd, input longint unsigned sa,
                            input longint unsigned sb, input longint unsigned sc,
                            input logic [5:0] lane, input logic act);
    in_item_t t;
    t.cmd = cmd; t.src_a = sa; t.src_b = sb; t.src_c = sc;
    t.lane_number = lane; t.lane_active = act;
    // idle between bursts
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      while (gap_left > 0) begin
        @(posedge clk_i);
        in_valid <= 1'b0;
        gap_left--;
      end
    end
    @(posedge clk_i);
    in_valid <= 1'b1;
    in_data <= t;
    expected_q.push_back(predict_lane(t));
    // hold until accepted
    do @(negedge clk_i); while (in_stall);
    burst_left--;
    sent_cnt++;
  endtask

  task automatic idle_input();
    @(posedge clk_i);
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  // ---------------- test tasks ----------------
  task automatic test_opcode_sweep();
    for (int op = 0; op < 64; op++)
      send_instr(op[5:0], rand64(), rand64(), rand64(), 6'($urandom), 1'b1);
  endtask

  task automatic test_corner_cases();
    send_instr(OP_ASHRREV_I64, 64'd4, 64'h8000_0000_0000_0000, 64'd0, 6'd0, 1'b1);
    send_instr(OP_BFE_I32, '1, 64'd3, 64'd0, 6'd0, 1'b1);
    send_instr(OP_BFE_U32, '1, 64'd31, 64'd32, 6'd0, 1'b1);
    send_instr(OP_PERM, 64'h8000_7fff, 64'h0080_8000, 64'h0b0a_0908, 6'd0, 1'b1);
    send_instr(OP_PERM, 64'h1234_5678, 64'h9abc_def0, 64'hff0d_0c07, 6'd0, 1'b1);
    send_instr(OP_MED3_I32, 64'h8000_0000, 64'h8000_0000, 64'd5, 6'd0, 1'b1);
    send_instr(OP_MED3_U16, 64'd7, 64'd7, 64'd7, 6'd0, 1'b1);
    send_instr(OP_CVT_PK_I16, 64'h8000_0000, 64'h7fff_ffff, 64'd0, 6'd0, 1'b1);
    send_instr(OP_CVT_PK_I16, 64'hffff_8000, 64'h0000_7fff, 64'd0, 6'd0, 1'b1);
    send_instr(OP_SAD_U8, 64'h00ff_00ff, 64'hff00_ff00, 64'hffff_ffff, 6'd0, 1'b1);
    send_instr(OP_MSAD_U8, 64'h00ff_00ff, 64'hff00_0000, 64'd1, 6'd0, 1'b1);
    send_instr(OP_MBCNT_LO, '1, 64'd0, 64'd0, 6'd63, 1'b1);
    send_instr(OP_MBCNT_HI, '1, 64'd0, 64'd0, 6'd63, 1'b1);
    send_instr(OP_ADDC_CO, 64'hffff_ffff, 64'd1, 64'd0, 6'd0, 1'b1);
    send_instr(OP_ADDC_CO, 64'hffff_ffff, 64'd1, 64'd0, 6'd0, 1'b0);
    send_instr(OP_RSV63, '1, '1, '1, 6'd63, 1'b1);
    send_instr(OP_RSV61, '1, '1, '1, 6'd0, 1'b0);
    send_instr(OP_LSHL_B64, '1, 64'd63, 64'd0, 6'd0, 1'b1);
  endtask

  task automatic test_random_mix(input int unsigned count);
    logic [5:0] op;
    for (int unsigned i = 0; i < count; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(61, 63))
                                        : 6'($urandom_range(0, 60));
      send_instr(op, rand64(), rand64(), rand64(), 6'($urandom),
                 $urandom_range(0, 7) != 0);
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    burst_left = count;
    for (int unsigned i = 0; i < count; i++)
      send_instr(6'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, 6'($urandom), 1'($urandom));
  endtask

  // ---------------- receiver stall pattern ----------------
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    if (cycle_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (cycle_cnt % 7) < 3;
    endcase
  end

  // ---------------- result checker ----------------
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with no pending transaction: %h", out_data);
        err_cnt++;
      end else begin
        e = expected_q.pop_front();
        checked_cnt++;
        if (out_data.dest_value !== e.dest_value) begin
          $error("dest_value: expected %h actual %h", e.dest_value, out_data.dest_value);
          err_cnt++;
        end
        if (out_data.carry_out !== e.carry_out) begin
          $error("carry_out: expected %b actual %b", e.carry_out, out_data.carry_out);
          err_cnt++;
        end
        if (out_data.carry_valid !== e.carry_valid) begin
          $error("carry_valid: expected %b actual %b", e.carry_valid, out_data.carry_valid);
          err_cnt++;
        end
        if (out_data.write_enable !== e.write_enable) begin
          $error("write_enable: expected %b actual %b", e.write_enable,
                 out_data.write_enable);
          err_cnt++;
        end
        if (out_data.unsupported !== e.unsupported) begin
          $error("unsupported: expected %b actual %b", e.unsupported, out_data.unsupported);
          err_cnt++;
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_corner_cases();
    test_opcode_sweep();
    test_random_mix(1500);
    test_back_to_back(200);
    idle_input();
    // drain outstanding results
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      err_cnt++;
    end
    $display("Sent %0d transactions over all 64 opcodes, checked %0d results.",
             sent_cnt, checked_cnt);
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
sv/vlia_pkg.sv
sv/vlia_front.sv
sv/vlia_queue.sv
sv/vlia_back.sv
sv/vector_lane_integer_alu_unit.sv
sim/testbench.sv
